// File: src/euclidean_distance_ceil_top_macros.svh
// Assertion macros for the rounded-up distance block.
// Included by the top level; depends on nothing else.
`ifndef EUCLIDEAN_DISTANCE_CEIL_TOP_MACROS_SVH
`define EUCLIDEAN_DISTANCE_CEIL_TOP_MACROS_SVH

// When ante holds at a clock edge, cons must hold at the same edge.
`define EDC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("edc check failed: same-cycle implication");

// When ante holds at a clock edge, cons must hold at the next edge.
`define EDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("edc check failed: next-cycle implication");

`endif

// File: src/edc_pkg.sv
// Shared constants for the rounded-up distance block.
// No dependencies; imported by the top level.
package edc_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int DIST_BITS      = 12;
    localparam int M_TDATA_W      = ((DIST_BITS + 7) / 8) * 8;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

endpackage

// File: src/edc_root_stage.sv
// One digit stage of the pipelined integer square root, with its own register.
// Self-contained; instantiated once per root bit by the top level.
module edc_root_stage #(
    parameter int ROOT_W = 12,
    parameter int RAD_W  = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ROOT_W-1:0] in_root,
    input  logic [ROOT_W+1:0] in_rem,
    input  logic [RAD_W-1:0]  in_rad,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROOT_W-1:0] out_root,
    output logic [ROOT_W+1:0] out_rem,
    output logic [RAD_W-1:0]  out_rad
);

    logic              valid_reg;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+3:0] cur, trial, diff;
    logic              take;

    // Bring down the next two radicand bits and try the digit one.
    always_comb begin
        cur       = {in_rem, in_rad[RAD_W-1 -: 2]};
        trial     = {2'b00, in_root, 2'b01};
        diff      = cur - trial;
        take      = !(cur < trial);
        rem_next  = take ? diff[ROOT_W+1:0] : cur[ROOT_W+1:0];
        root_next = {in_root[ROOT_W-2:0], take};
        rad_next  = {in_rad[RAD_W-3:0], 2'b00};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            root_reg <= root_next;
            rem_reg  <= rem_next;
            rad_reg  <= rad_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;
    assign out_rad   = rad_reg;

endmodule

// File: src/euclidean_distance_ceil_top.sv
// Usage
//   Takes two signed grid points per input word and returns the Euclidean
//   distance between them rounded up, ceil(sqrt(dx*dx + dy*dy)), exactly.
//   Input channel s_axis_*: one word holds first_x, first_y, second_x and
//   second_y, each COORD_BITS wide. Result channel m_axis_*: dist_up, 12 bits,
//   saturating at 4095 should a wide COORD_BITS ever need more.
//   Throughput is one word per cycle while m_axis_tready stays high. Between
//   input and result lie four front stages (difference, magnitude, square,
//   sum), one stage per root bit in the digit-by-digit square root
//   (COORD_BITS + 1 stages), and one output stage that rounds up and saturates.
//   Every stage holds its own valid bit; a stage advances when it is empty or
//   the stage after it moves, so bubbles are squeezed out and words keep
//   entering while a result waits. When m_axis_tready stays low the pipeline
//   fills and s_axis_tready falls; nothing is dropped or repeated.
//   Reset (aresetn low at a clock edge) empties every stage; the block has no
//   other state.
// Depends on edc_pkg, edc_root_stage and the assertion macro header.
`include "euclidean_distance_ceil_top_macros.svh"

module euclidean_distance_ceil_top #(
    parameter int COORD_BITS = edc_pkg::COORD_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // fields from bit 0 up: first_x, first_y, second_x, second_y, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // fields from bit 0 up: dist_up, zero pad
    output logic [edc_pkg::M_TDATA_W-1:0]         m_axis_tdata
);

    import edc_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int SQW   = 2 * CW;
    localparam int SW    = SQW + 1;
    localparam int R     = CW + 1;
    localparam int RAD_W = 2 * R;
    localparam int XW    = (R + 1 > DIST_BITS) ? R + 1 : DIST_BITS;

    // Field extraction
    logic [CW-1:0] fx, fy, sx, sy;
    assign fx = s_axis_tdata[0*CW +: CW];
    assign fy = s_axis_tdata[1*CW +: CW];
    assign sx = s_axis_tdata[2*CW +: CW];
    assign sy = s_axis_tdata[3*CW +: CW];

    logic rdy1, rdy2, rdy3, rdy4, rdy_out;

    // Stage 1: signed differences
    logic          v1_reg;
    logic [DW-1:0] dx1_reg, dy1_reg, dx1_next, dy1_next;
    assign dx1_next = {fx[CW-1], fx} - {sx[CW-1], sx};
    assign dy1_next = {fy[CW-1], fy} - {sy[CW-1], sy};
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_axis_tvalid) begin
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
        end
    end

    // Stage 2: magnitudes; a difference never reaches -2^CW, so CW bits hold it.
    logic          v2_reg;
    logic [CW-1:0] ax2_reg, ay2_reg, ax2_next, ay2_next;
    logic [DW-1:0] ndx, ndy;
    assign ndx = -dx1_reg;
    assign ndy = -dy1_reg;
    assign ax2_next = dx1_reg[DW-1] ? ndx[CW-1:0] : dx1_reg[CW-1:0];
    assign ay2_next = dy1_reg[DW-1] ? ndy[CW-1:0] : dy1_reg[CW-1:0];
    assign rdy2 = !v2_reg || rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            ax2_reg <= ax2_next;
            ay2_reg <= ay2_next;
        end
    end

    // Stage 3: squares
    logic           v3_reg;
    logic [SQW-1:0] sqx3_reg, sqy3_reg, sqx3_next, sqy3_next;
    assign sqx3_next = SQW'(ax2_reg) * SQW'(ax2_reg);
    assign sqy3_next = SQW'(ay2_reg) * SQW'(ay2_reg);
    assign rdy3 = !v3_reg || rdy4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            sqx3_reg <= sqx3_next;
            sqy3_reg <= sqy3_next;
        end
    end

    // Stage 4: sum of squares
    logic          v4_reg;
    logic [SW-1:0] sum4_reg, sum4_next;
    assign sum4_next = SW'(sqx3_reg) + SW'(sqy3_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            sum4_reg <= sum4_next;
        end
    end

    // Square root, one result bit per stage
    logic             rt_valid [0:R];
    logic             rt_ready [0:R];
    logic [R-1:0]     rt_root  [0:R];
    logic [R+1:0]     rt_rem   [0:R];
    logic [RAD_W-1:0] rt_rad   [0:R];

    assign rt_valid[0] = v4_reg;
    assign rt_root[0]  = '0;
    assign rt_rem[0]   = '0;
    assign rt_rad[0]   = RAD_W'(sum4_reg);
    assign rdy4        = !v4_reg || rt_ready[0];
    assign rt_ready[R] = rdy_out;

    genvar gi;
    generate
        for (gi = 0; gi < R; gi++) begin : g_root
            edc_root_stage #(
                .ROOT_W (R),
                .RAD_W  (RAD_W)
            ) u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (rt_valid[gi]),
                .in_ready  (rt_ready[gi]),
                .in_root   (rt_root[gi]),
                .in_rem    (rt_rem[gi]),
                .in_rad    (rt_rad[gi]),
                .out_valid (rt_valid[gi+1]),
                .out_ready (rt_ready[gi+1]),
                .out_root  (rt_root[gi+1]),
                .out_rem   (rt_rem[gi+1]),
                .out_rad   (rt_rad[gi+1])
            );
        end
    endgenerate

    // Output stage: a nonzero remainder means the floor root falls short.
    logic                 vo_reg;
    logic [DIST_BITS-1:0] dist_reg, dist_next;
    logic [XW-1:0]        ceil_root;
    assign ceil_root = XW'(rt_root[R]) + XW'(rt_rem[R] != '0);
    assign dist_next = (ceil_root > XW'(DIST_MAX)) ? DIST_MAX : ceil_root[DIST_BITS-1:0];
    assign rdy_out   = !vo_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (rdy_out) begin
            vo_reg <= rt_valid[R];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out && rt_valid[R]) begin
            dist_reg <= dist_next;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = M_TDATA_W'(dist_reg);

    // An empty output register must let the whole pipeline move.
    `EDC_ASSERT_NOW(a_ready_when_drained, aclk, aresetn, !m_axis_tvalid, s_axis_tready)
    // A taken result with nothing behind it leaves the output empty.
    `EDC_ASSERT_NEXT(a_drain_empties, aclk, aresetn,
        m_axis_tvalid && m_axis_tready && !rt_valid[R], !m_axis_tvalid)
    // The final remainder of a floor root never exceeds twice the root.
    `EDC_ASSERT_NOW(a_root_remainder, aclk, aresetn, rt_valid[R],
        rt_rem[R] <= {rt_root[R], 1'b0})

endmodule
